FILE: design/kop_pkg.sv
`default_nettype none
package kop_pkg;

  localparam int NEWTON_STEPS = 7;
  localparam int ANGLE_BITS   = 16;
  localparam int AB_REG       = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

  // Division cells: one quotient bit per cell.
  localparam int PHASE_CELLS  = 49;
  localparam int STEP_CELLS   = 62;

  // Square root sequencer and the input hold-off that covers it.
  localparam int SQRT_STEPS   = 31;
  localparam int HOLD_CYC     = 40;
  localparam int SQ_LAST      = HOLD_CYC - SQRT_STEPS;

  localparam logic [2:0] REG_SEMI   = 3'd0;
  localparam logic [2:0] REG_PERIOD = 3'd1;
  localparam logic [2:0] REG_EPOCH  = 3'd2;
  localparam logic [2:0] REG_MAE    = 3'd3;
  localparam logic [2:0] REG_ECC    = 3'd4;
  localparam logic [2:0] REG_PERI   = 3'd5;
  localparam logic [2:0] REG_NODE   = 3'd6;
  localparam logic [2:0] REG_TILT   = 3'd7;

  localparam logic [15:0] ECC_MAX = 16'd60293;

  typedef logic signed [33:0] kop_q_t;
  typedef logic signed [35:0] kop_w_t;

  localparam kop_w_t Q30_ONE         = 36'sd1073741824;
  localparam kop_q_t PI_HALF_Q30     = 34'sd1686629713;
  localparam kop_q_t TWO_OVER_PI_Q30 = 34'sd683565276;
  localparam kop_q_t MIN_SLOPE       = 34'sd11;

  localparam kop_q_t SIN_C0 = 34'sd2959;
  localparam kop_w_t SIN_C1 = -36'sd213044;
  localparam kop_w_t SIN_C2 = 36'sd8947849;
  localparam kop_w_t SIN_C3 = -36'sd178956971;
  localparam kop_q_t COS_C0 = -34'sd296;
  localparam kop_w_t COS_C1 = 36'sd26630;
  localparam kop_w_t COS_C2 = -36'sd1491308;
  localparam kop_w_t COS_C3 = 36'sd44739243;
  localparam kop_w_t COS_C4 = -36'sd536870912;

  typedef struct packed {
    logic signed [47:0] time_ms;
    logic signed [31:0] parent_x;
    logic signed [31:0] parent_y;
    logic signed [31:0] parent_z;
    logic               hold_at_parent;
  } kop_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } kop_out_t;

  // Context of one transaction as it moves down the pipeline.
  typedef struct packed {
    logic               valid;
    logic               hold;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [31:0]        mean;
    logic [31:0]        ea;
  } kop_tok_t;

  // State of a long division, handed from cell to cell.
  typedef struct packed {
    logic [39:0] rem;
    logic [63:0] dvd;
    logic [31:0] quo;
    logic [39:0] dsr;
    logic        neg;
  } kop_div_t;

  // Q30 product, rounded to nearest with ties away from zero.
  function automatic kop_w_t qmul(input kop_q_t a, input kop_q_t b);
    logic [33:0] ua;
    logic [33:0] ub;
    logic [67:0] p;
    logic [35:0] m;
    ua = a[33] ? 34'(-a) : 34'(a);
    ub = b[33] ? 34'(-b) : 34'(b);
    p  = ua * ub + 68'd536870912;
    m  = {1'b0, p[64:30]};
    return (a[33] ^ b[33]) ? -m : m;
  endfunction

  function automatic kop_q_t trim(input kop_w_t v);
    return v[33:0];
  endfunction

  function automatic kop_q_t qadd(input kop_w_t a, input kop_w_t b);
    kop_w_t s;
    s = a + b;
    return s[33:0];
  endfunction

  // Register angle as a 32-bit turn fraction, cut to the angle resolution.
  function automatic logic [31:0] reg_angle(input logic [15:0] r);
    return {r[15 -: AB_REG], {(32 - AB_REG){1'b0}}};
  endfunction

endpackage
`default_nettype wire

FILE: design/kop_div_cell.sv
`default_nettype none
module kop_div_cell import kop_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire kop_tok_t tok_i,
  input  wire kop_div_t div_i,
  output kop_tok_t      tok_o,
  output kop_div_t      div_o
);

  kop_tok_t    tok_r;
  kop_div_t    div_r;
  kop_div_t    div_nxt;
  logic [40:0] trial;
  logic [40:0] diff;
  logic        ge;

  // Restoring step: bring in the next dividend bit and subtract if it fits.
  always_comb begin
    trial       = {div_i.rem, div_i.dvd[63]};
    ge          = trial >= {1'b0, div_i.dsr};
    diff        = trial - {1'b0, div_i.dsr};
    div_nxt     = div_i;
    div_nxt.rem = ge ? diff[39:0] : trial[39:0];
    div_nxt.dvd = {div_i.dvd[62:0], 1'b0};
    div_nxt.quo = {div_i.quo[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else if (en) begin
      tok_r <= tok_i;
      div_r <= div_nxt;
    end
  end

  assign tok_o = tok_r;
  assign div_o = div_r;

endmodule
`default_nettype wire

FILE: design/kop_sincos.sv
`default_nettype none
module kop_sincos import kop_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic [31:0] ang_i,
  input  wire kop_tok_t    tok_i,
  output kop_q_t           s_o,
  output kop_q_t           c_o,
  output kop_tok_t         tok_o
);

  kop_q_t     x_r  [1:6];
  kop_q_t     x2_r [2:6];
  kop_q_t     ts_r [3:6];
  kop_q_t     tc_r [3:6];
  logic [2:0] qf_r [1:6];
  kop_tok_t   tok_r [1:7];
  kop_q_t     s_r;
  kop_q_t     c_r;

  kop_q_t     x_nxt;
  kop_q_t     x2_nxt;
  kop_q_t     ts3_nxt, ts4_nxt, ts5_nxt, ts6_nxt;
  kop_q_t     tc3_nxt, tc4_nxt, tc5_nxt, tc6_nxt;
  kop_q_t     s_nxt;
  kop_q_t     c_nxt;
  logic [2:0] qf_nxt;
  logic [29:0] r;
  logic [30:0] rr;
  kop_q_t     xin;
  kop_q_t     sn;
  kop_q_t     cs;
  kop_q_t     s0;
  kop_q_t     c0;

  always_comb begin
    // Fold the quarter turn onto [0, 1/8] turn; flip swaps sine and cosine.
    r      = ang_i[29:0];
    qf_nxt = {ang_i[31:30], (r > 30'h20000000)};
    rr     = qf_nxt[0] ? (31'h40000000 - {1'b0, r}) : {1'b0, r};
    xin    = {3'b000, rr};
    x_nxt  = trim(qmul(xin, PI_HALF_Q30));
    x2_nxt = trim(qmul(x_r[1], x_r[1]));
    ts3_nxt = qadd(SIN_C1, qmul(x2_r[2], SIN_C0));
    tc3_nxt = qadd(COS_C1, qmul(x2_r[2], COS_C0));
    ts4_nxt = qadd(SIN_C2, qmul(x2_r[3], ts_r[3]));
    tc4_nxt = qadd(COS_C2, qmul(x2_r[3], tc_r[3]));
    ts5_nxt = qadd(SIN_C3, qmul(x2_r[4], ts_r[4]));
    tc5_nxt = qadd(COS_C3, qmul(x2_r[4], tc_r[4]));
    ts6_nxt = qadd(Q30_ONE, qmul(x2_r[5], ts_r[5]));
    tc6_nxt = qadd(COS_C4, qmul(x2_r[5], tc_r[5]));
    sn      = trim(qmul(x_r[6], ts_r[6]));
    cs      = qadd(Q30_ONE, qmul(x2_r[6], tc_r[6]));
    s0      = qf_r[6][0] ? cs : sn;
    c0      = qf_r[6][0] ? sn : cs;
    case (qf_r[6][2:1])
      2'd0: begin
        s_nxt = s0;
        c_nxt = c0;
      end
      2'd1: begin
        s_nxt = c0;
        c_nxt = -s0;
      end
      2'd2: begin
        s_nxt = -s0;
        c_nxt = -c0;
      end
      default: begin
        s_nxt = -c0;
        c_nxt = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= 7; i++) begin
        tok_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      tok_r[1] <= tok_i;
      for (int i = 2; i <= 7; i++) begin
        tok_r[i] <= tok_r[i-1];
      end
      x_r[1]  <= x_nxt;
      qf_r[1] <= qf_nxt;
      for (int i = 2; i <= 6; i++) begin
        x_r[i]  <= x_r[i-1];
        qf_r[i] <= qf_r[i-1];
      end
      x2_r[2] <= x2_nxt;
      for (int i = 3; i <= 6; i++) begin
        x2_r[i] <= x2_r[i-1];
      end
      ts_r[3] <= ts3_nxt;
      tc_r[3] <= tc3_nxt;
      ts_r[4] <= ts4_nxt;
      tc_r[4] <= tc4_nxt;
      ts_r[5] <= ts5_nxt;
      tc_r[5] <= tc5_nxt;
      ts_r[6] <= ts6_nxt;
      tc_r[6] <= tc6_nxt;
      s_r     <= s_nxt;
      c_r     <= c_nxt;
    end
  end

  assign s_o   = s_r;
  assign c_o   = c_r;
  assign tok_o = tok_r[7];

endmodule
`default_nettype wire

FILE: design/kop_newton.sv
`default_nettype none
module kop_newton import kop_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire kop_q_t   e30,
  input  wire kop_tok_t tok_i,
  output kop_tok_t      tok_o
);

  kop_q_t   se;
  kop_q_t   ce;
  kop_tok_t tok_s;

  kop_tok_t           tok_a_r;
  kop_q_t             p1_r, p1_nxt;
  kop_q_t             sl_r, sl_nxt;
  logic signed [31:0] d_r, d_nxt;

  kop_tok_t           tok_b_r;
  kop_div_t           div_b_r, div_b_nxt;
  logic signed [36:0] f;
  logic [36:0]        nf;
  kop_w_t             p2;
  kop_q_t             slope;

  kop_tok_t ch_tok [0:STEP_CELLS];
  kop_div_t ch_div [0:STEP_CELLS];

  kop_tok_t tok_c_r, tok_c_nxt;
  kop_div_t div_e;

  kop_sincos u_sc (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ang_i (tok_i.ea),
    .tok_i (tok_i),
    .s_o   (se),
    .c_o   (ce),
    .tok_o (tok_s)
  );

  always_comb begin
    p1_nxt = trim(qmul(e30, se));
    sl_nxt = qadd(Q30_ONE, -qmul(e30, ce));
    d_nxt  = tok_s.ea - tok_s.mean;

    // Residual in turns, then the divider works on its magnitude shifted to Q30.
    p2    = qmul(p1_r, TWO_OVER_PI_Q30);
    f     = {{5{d_r[31]}}, d_r} - {p2[35], p2};
    nf    = -f;
    slope = (sl_r < MIN_SLOPE) ? MIN_SLOPE : sl_r;
    div_b_nxt.rem = '0;
    div_b_nxt.dvd = {(f[36] ? nf[31:0] : f[31:0]), 32'd0};
    div_b_nxt.quo = '0;
    div_b_nxt.dsr = {8'd0, slope[31:0]};
    div_b_nxt.neg = f[36];

    // Only the low word of the quotient matters: the angle wraps each turn.
    div_e     = ch_div[STEP_CELLS];
    tok_c_nxt = ch_tok[STEP_CELLS];
    tok_c_nxt.ea = div_e.neg ? (ch_tok[STEP_CELLS].ea + div_e.quo)
                             : (ch_tok[STEP_CELLS].ea - div_e.quo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_a_r.valid <= 1'b0;
      tok_b_r.valid <= 1'b0;
      tok_c_r.valid <= 1'b0;
    end else if (en) begin
      tok_a_r <= tok_s;
      p1_r    <= p1_nxt;
      sl_r    <= sl_nxt;
      d_r     <= d_nxt;
      tok_b_r <= tok_a_r;
      div_b_r <= div_b_nxt;
      tok_c_r <= tok_c_nxt;
    end
  end

  assign ch_tok[0] = tok_b_r;
  assign ch_div[0] = div_b_r;

  for (genvar i = 0; i < STEP_CELLS; i++) begin : g_cell
    kop_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (ch_tok[i]),
      .div_i (ch_div[i]),
      .tok_o (ch_tok[i+1]),
      .div_o (ch_div[i+1])
    );
  end

  assign tok_o = tok_c_r;

endmodule
`default_nettype wire

FILE: design/kepler_orbit_position_core.sv
`default_nettype none
// Channel  | Handshake              | Payload
// in       | in_valid / in_ready    | in_data (kop_in_t)
// out      | out_valid / out_ready  | out_data (kop_out_t)
// cfg      | cfg_we                 | cfg_index, cfg_data
//
// One transaction enters per cycle while in_ready is high. The pipeline holds
// division cells: 49 + ANGLE_BITS for the phase and 62 per Newton step.
// After reset and after every register write in_ready stays low while
// the square root of 1 - e^2 is found one bit a cycle and the sines and cosines of the register angles settle.
// A result that is not taken freezes the whole pipeline, and in_ready with it.
module kepler_orbit_position_core import kop_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire kop_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output kop_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  logic [30:0] semi_r;
  logic [39:0] period_r;
  logic [47:0] epoch_r;
  logic [15:0] mae_r;
  logic [15:0] ecc_r;
  logic [15:0] peri_r;
  logic [15:0] node_r;
  logic [15:0] tilt_r;

  logic [5:0]  hc_r;
  logic [32:0] sq_rem_r, sq_rem_nxt;
  logic [30:0] sq_root_r, sq_root_nxt;
  logic [15:0] ecc_c;
  logic [32:0] esq;
  logic [30:0] sub;
  logic [61:0] vv;
  logic [4:0]  sq_idx;
  logic [34:0] sq_rs;
  logic [34:0] sq_tr;
  logic        sq_act;

  kop_q_t e30;
  kop_q_t bf;
  kop_q_t sw, cw, so, co, si, ci;

  logic pipe_en;

  kop_tok_t           tok0_r, tok0_nxt;
  logic signed [48:0] dt0_r, dt0_nxt;
  kop_tok_t           tok1_r;
  kop_div_t           div1_r, div1_nxt;
  logic [48:0]        ndt;
  kop_tok_t           tok2_r;
  kop_div_t           div2_r, div2_nxt;
  kop_tok_t           tok3_r, tok3_nxt;
  logic [ANGLE_BITS-1:0] m_ab;
  logic [31:0]        mae_ang;

  kop_tok_t ph_tok [0:PHASE_CELLS];
  kop_div_t ph_div [0:PHASE_CELLS];
  kop_tok_t fr_tok [0:ANGLE_BITS];
  kop_div_t fr_div [0:ANGLE_BITS];
  kop_tok_t nt_tok [0:NEWTON_STEPS];

  kop_q_t   se, ce;
  kop_tok_t tok_f0;

  kop_tok_t tok_f1_r, tok_f2_r, tok_f3_r, tok_f4_r, tok_f5_r;
  kop_q_t   cx_r, sy_r, cx_nxt, sy_nxt;
  kop_q_t   xp_r, yp_r, xp_nxt, yp_nxt;
  kop_q_t   xp3_r, yc_r, uz_r, yc_nxt, uz_nxt;
  kop_q_t   ux_r, uy_r, uz4_r, ux_nxt, uy_nxt;
  kop_w_t   mx_r, my_r, mz_r, mx_nxt, my_nxt, mz_nxt;
  kop_q_t   a_q;
  kop_w_t   sx, sy_sum, sz;

  logic     out_valid_r;
  kop_out_t out_r, out_nxt;

  function automatic logic [31:0] sat32(input kop_w_t v);
    if (v > 36'sd2147483647) begin
      return 32'h7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'h80000000;
    end
    return v[31:0];
  endfunction

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      semi_r   <= '0;
      period_r <= '0;
      epoch_r  <= '0;
      mae_r    <= '0;
      ecc_r    <= '0;
      peri_r   <= '0;
      node_r   <= '0;
      tilt_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEMI:   semi_r   <= cfg_data[30:0];
        REG_PERIOD: period_r <= cfg_data[39:0];
        REG_EPOCH:  epoch_r  <= cfg_data;
        REG_MAE:    mae_r    <= cfg_data[15:0];
        REG_ECC:    ecc_r    <= cfg_data[15:0];
        REG_PERI:   peri_r   <= cfg_data[15:0];
        REG_NODE:   node_r   <= cfg_data[15:0];
        REG_TILT:   tilt_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Quantities that follow from the registers alone.
  always_comb begin
    ecc_c  = (ecc_r > ECC_MAX) ? ECC_MAX : ecc_r;
    e30    = {4'b0000, ecc_c, 14'd0};
    esq    = (33'(ecc_c) * 33'(ecc_c) + 33'd2) >> 2;
    sub    = 31'h40000000 - esq[30:0];
    vv     = {1'b0, sub, 30'd0};
    sq_act = (hc_r < 6'(HOLD_CYC)) && (hc_r >= 6'(SQ_LAST));
    sq_idx = 5'(hc_r - 6'(SQ_LAST));
    sq_rs  = {sq_rem_r, vv[{sq_idx, 1'b0} +: 2]};
    sq_tr  = {2'b00, sq_root_r, 2'b01};
    sq_rem_nxt  = sq_rem_r;
    sq_root_nxt = sq_root_r;
    if (hc_r == 6'(HOLD_CYC)) begin
      sq_rem_nxt  = '0;
      sq_root_nxt = '0;
    end else if (sq_act) begin
      if (sq_rs >= sq_tr) begin
        sq_rem_nxt  = 33'(sq_rs - sq_tr);
        sq_root_nxt = {sq_root_r[29:0], 1'b1};
      end else begin
        sq_rem_nxt  = sq_rs[32:0];
        sq_root_nxt = {sq_root_r[29:0], 1'b0};
      end
    end
    bf = {3'b000, sq_root_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= 6'(HOLD_CYC);
    end else if (cfg_we) begin
      hc_r <= 6'(HOLD_CYC);
    end else if (hc_r != 6'd0) begin
      hc_r <= hc_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r  <= sq_rem_nxt;
    sq_root_r <= sq_root_nxt;
  end

  kop_sincos u_sc_peri (
    .clk (clk), .rst_n (rst_n), .en (1'b1), .ang_i (reg_angle(peri_r)),
    .tok_i ('0), .s_o (sw), .c_o (cw), .tok_o ()
  );
  kop_sincos u_sc_node (
    .clk (clk), .rst_n (rst_n), .en (1'b1), .ang_i (reg_angle(node_r)),
    .tok_i ('0), .s_o (so), .c_o (co), .tok_o ()
  );
  kop_sincos u_sc_tilt (
    .clk (clk), .rst_n (rst_n), .en (1'b1), .ang_i (reg_angle(tilt_r)),
    .tok_i ('0), .s_o (si), .c_o (ci), .tok_o ()
  );

  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en && (hc_r == 6'd0);

  // Entry, phase division set-up, the fix-up to a floor remainder and the mean anomaly.
  always_comb begin
    tok0_nxt.valid = in_valid && in_ready;
    tok0_nxt.hold  = in_data.hold_at_parent || (semi_r == '0) || (period_r == '0);
    tok0_nxt.px    = in_data.parent_x;
    tok0_nxt.py    = in_data.parent_y;
    tok0_nxt.pz    = in_data.parent_z;
    tok0_nxt.mean  = '0;
    tok0_nxt.ea    = '0;
    dt0_nxt = {in_data.time_ms[47], in_data.time_ms} - {epoch_r[47], epoch_r};

    ndt          = -dt0_r;
    div1_nxt.rem = '0;
    div1_nxt.dvd = {(dt0_r[48] ? ndt : dt0_r), 15'd0};
    div1_nxt.quo = '0;
    div1_nxt.dsr = period_r;
    div1_nxt.neg = dt0_r[48];

    div2_nxt     = ph_div[PHASE_CELLS];
    if (ph_div[PHASE_CELLS].neg && (ph_div[PHASE_CELLS].rem != '0)) begin
      div2_nxt.rem = period_r - ph_div[PHASE_CELLS].rem;
    end
    div2_nxt.dvd = '0;
    div2_nxt.quo = '0;

    mae_ang       = reg_angle(mae_r);
    m_ab          = mae_ang[31 -: ANGLE_BITS] + fr_div[ANGLE_BITS].quo[ANGLE_BITS-1:0];
    tok3_nxt      = fr_tok[ANGLE_BITS];
    tok3_nxt.mean = {m_ab, {(32 - ANGLE_BITS){1'b0}}};
    tok3_nxt.ea   = {m_ab, {(32 - ANGLE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r.valid <= 1'b0;
      tok1_r.valid <= 1'b0;
      tok2_r.valid <= 1'b0;
      tok3_r.valid <= 1'b0;
    end else if (pipe_en) begin
      tok0_r <= tok0_nxt;
      dt0_r  <= dt0_nxt;
      tok1_r <= tok0_r;
      div1_r <= div1_nxt;
      tok2_r <= ph_tok[PHASE_CELLS];
      div2_r <= div2_nxt;
      tok3_r <= tok3_nxt;
    end
  end

  assign ph_tok[0] = tok1_r;
  assign ph_div[0] = div1_r;

  for (genvar i = 0; i < PHASE_CELLS; i++) begin : g_phase
    kop_div_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (pipe_en),
      .tok_i (ph_tok[i]), .div_i (ph_div[i]),
      .tok_o (ph_tok[i+1]), .div_o (ph_div[i+1])
    );
  end

  assign fr_tok[0] = tok2_r;
  assign fr_div[0] = div2_r;

  for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_frac
    kop_div_cell u_cell (
      .clk (clk), .rst_n (rst_n), .en (pipe_en),
      .tok_i (fr_tok[i]), .div_i (fr_div[i]),
      .tok_o (fr_tok[i+1]), .div_o (fr_div[i+1])
    );
  end

  assign nt_tok[0] = tok3_r;

  for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_newton
    kop_newton u_nt (
      .clk (clk), .rst_n (rst_n), .en (pipe_en), .e30 (e30),
      .tok_i (nt_tok[k]), .tok_o (nt_tok[k+1])
    );
  end

  kop_sincos u_sc_ea (
    .clk (clk), .rst_n (rst_n), .en (pipe_en), .ang_i (nt_tok[NEWTON_STEPS].ea),
    .tok_i (nt_tok[NEWTON_STEPS]), .s_o (se), .c_o (ce), .tok_o (tok_f0)
  );

  // Orbital plane, the three rotations, scaling and the saturated parent offset, or the parent alone on hold.
  always_comb begin
    cx_nxt = qadd({{2{ce[33]}}, ce}, -{{2{e30[33]}}, e30});
    sy_nxt = trim(qmul(bf, se));
    xp_nxt = qadd(qmul(cx_r, cw), -qmul(sy_r, sw));
    yp_nxt = qadd(qmul(cx_r, sw), qmul(sy_r, cw));
    yc_nxt = trim(qmul(yp_r, ci));
    uz_nxt = trim(qmul(yp_r, si));
    ux_nxt = qadd(qmul(xp3_r, co), -qmul(yc_r, so));
    uy_nxt = qadd(qmul(xp3_r, so), qmul(yc_r, co));
    a_q    = {3'b000, semi_r};
    mx_nxt = qmul(a_q, ux_r);
    my_nxt = qmul(a_q, uy_r);
    mz_nxt = qmul(a_q, uz4_r);
    sx     = {{4{tok_f5_r.px[31]}}, tok_f5_r.px} + mx_r;
    sy_sum = {{4{tok_f5_r.py[31]}}, tok_f5_r.py} + my_r;
    sz     = {{4{tok_f5_r.pz[31]}}, tok_f5_r.pz} + mz_r;
    if (tok_f5_r.hold) begin
      out_nxt.pos_x = tok_f5_r.px;
      out_nxt.pos_y = tok_f5_r.py;
      out_nxt.pos_z = tok_f5_r.pz;
    end else begin
      out_nxt.pos_x = sat32(sx);
      out_nxt.pos_y = sat32(sy_sum);
      out_nxt.pos_z = sat32(sz);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_f1_r.valid <= 1'b0;
      tok_f2_r.valid <= 1'b0;
      tok_f3_r.valid <= 1'b0;
      tok_f4_r.valid <= 1'b0;
      tok_f5_r.valid <= 1'b0;
      out_valid_r    <= 1'b0;
    end else if (pipe_en) begin
      tok_f1_r    <= tok_f0;
      cx_r        <= cx_nxt;
      sy_r        <= sy_nxt;
      tok_f2_r    <= tok_f1_r;
      xp_r        <= xp_nxt;
      yp_r        <= yp_nxt;
      tok_f3_r    <= tok_f2_r;
      xp3_r       <= xp_r;
      yc_r        <= yc_nxt;
      uz_r        <= uz_nxt;
      tok_f4_r    <= tok_f3_r;
      ux_r        <= ux_nxt;
      uy_r        <= uy_nxt;
      uz4_r       <= uz_r;
      tok_f5_r    <= tok_f4_r;
      mx_r        <= mx_nxt;
      my_r        <= my_nxt;
      mz_r        <= mz_nxt;
      out_valid_r <= tok_f5_r.valid;
      out_r       <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

FILE: design/kop_checker.sv
`default_nettype none
module kop_checker import kop_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_ready,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire kop_out_t out_data,
  input wire logic     cfg_we
);

  // A result that is not taken stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // A register write must keep new transactions out while derived values settle.
  a_cfg_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input accepted straight after a register write");

  // The pipeline freezes as a whole behind a stalled result.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the result stage is stalled");

endmodule

bind kepler_orbit_position_core kop_checker u_kop_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_we    (cfg_we)
);
`default_nettype wire
